// ===== rtl/ils_pkg.sv =====
// ----------------------------------------------------------------------------
// ils_pkg
// Shared widths, request codes, status codes and the result word type.
// ----------------------------------------------------------------------------
package ils_pkg;

  localparam int CAPACITY_DEF = 256;
  localparam int DATA_W       = 32;
  localparam int POS_W        = 9;
  localparam int MODE_W       = 3;
  localparam int STAT_W       = 2;
  localparam int CNT_OUT_W    = 9;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 3'd0,
    MODE_APPEND = 3'd1,
    MODE_FRONT  = 3'd2,
    MODE_REMOVE = 3'd3,
    MODE_READ   = 3'd4,
    MODE_WRITE  = 3'd5,
    MODE_CLEAR  = 3'd6
  } mode_t;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_BOUNDS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

  // value returned by a read that misses
  localparam logic signed [DATA_W-1:0] RD_MISS = 32'sd1;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [STAT_W-1:0]        status;
    logic [CNT_OUT_W-1:0]     element_count;
    logic                     is_empty;
  } rsp_t;

endpackage

// ===== rtl/ils_if.sv =====
// ----------------------------------------------------------------------------
// ils_if
// Valid/ready channels: request word in, result word out.
// ----------------------------------------------------------------------------
interface ils_req_if import ils_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output mode, output position, output value, input ready);
  modport sink   (input valid, input mode, input position, input value, output ready);
endinterface

interface ils_rsp_if import ils_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] read_value;
  logic [STAT_W-1:0]        status;
  logic [CNT_OUT_W-1:0]     element_count;
  logic                     is_empty;

  modport source (output valid, output read_value, output status, output element_count,
                  output is_empty, input ready);
  modport sink   (input valid, input read_value, input status, input element_count,
                  input is_empty, output ready);
endinterface

// ===== rtl/indexed_list_store_unit.sv =====
// ----------------------------------------------------------------------------
// indexed_list_store_unit
// Ordered list of signed 32-bit words in a bounded store with an element count.
// Insert below the count moves the entries from the top down to the slot up
//   by one, then writes the new value; remove moves the entries above the slot
//   down by one, one entry at a time on the store's read and write ports.
// Throughput: one request at a time; the next waits for the result handover.
// Reset: synchronous rst empties the list; store contents are not cleared.
// ----------------------------------------------------------------------------
module indexed_list_store_unit import ils_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic     clk,
  input  logic     rst,
  ils_req_if.sink  req,
  ils_rsp_if.source rsp
);

  localparam int AW = $clog2(CAPACITY);

  // store port
  logic                     mem_wr_en;
  logic [AW-1:0]            mem_wr_addr;
  logic signed [DATA_W-1:0] mem_wr_data;
  logic                     mem_rd_en;
  logic [AW-1:0]            mem_rd_addr;
  logic signed [DATA_W-1:0] mem_rd_data;

  // finished result from the sequencer
  logic res_valid;
  logic res_ready;
  rsp_t res;

  ils_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  ils_mem #(
    .CAPACITY (CAPACITY)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Output register: the sequencer hands over a word when this slot is free
  // or being drained, so the next request can start while a word waits here.
  assign res_ready = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        rsp.valid         <= 1'b1;
        rsp.read_value    <= res.read_value;
        rsp.status        <= res.status;
        rsp.element_count <= res.element_count;
        rsp.is_empty      <= res.is_empty;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/ils_mem.sv =====
// ----------------------------------------------------------------------------
// ils_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ils_mem import ils_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  localparam int AW = $clog2(CAPACITY)
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [AW-1:0]            wr_addr,
  input  logic signed [DATA_W-1:0] wr_data,
  input  logic                     rd_en,
  input  logic [AW-1:0]            rd_addr,
  output logic signed [DATA_W-1:0] rd_data
);

  logic signed [DATA_W-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/ils_ctrl.sv =====
// ----------------------------------------------------------------------------
// ils_ctrl
// Request decode, element count and the shift sequencer over the store.
// ----------------------------------------------------------------------------
module ils_ctrl import ils_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  localparam int AW = $clog2(CAPACITY)
) (
  input  logic                     clk,
  input  logic                     rst,
  ils_req_if.sink                  req,
  output logic                     mem_wr_en,
  output logic [AW-1:0]            mem_wr_addr,
  output logic signed [DATA_W-1:0] mem_wr_data,
  output logic                     mem_rd_en,
  output logic [AW-1:0]            mem_rd_addr,
  input  logic signed [DATA_W-1:0] mem_rd_data,
  output logic                     res_valid,
  input  logic                     res_ready,
  output rsp_t                     res
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,     // insert: move entries up, top down to the slot
    S_FILL,   // insert: write the new value into the opened slot
    S_DN,     // remove: move entries down, slot upward
    S_RD,     // read data returning from the store
    S_DONE
  } state_t;

  state_t                   state;
  logic [CW-1:0]            count;
  logic [AW-1:0]            ptr;
  logic [AW-1:0]            pos_reg;
  logic signed [DATA_W-1:0] val_reg;
  logic [STAT_W-1:0]        res_st;
  logic signed [DATA_W-1:0] res_rd;

  // decode of the word at the input
  logic [XW-1:0]            pos_x;
  logic [XW-1:0]            cnt_x;
  logic [XW-1:0]            cnt_m1;
  logic [XW-1:0]            pos_p1;
  logic [XW-1:0]            ins_x;
  logic                     full;
  state_t                   d_next;
  logic [CW-1:0]            d_cnt;
  logic [STAT_W-1:0]        d_st;
  logic signed [DATA_W-1:0] d_rd;
  logic [AW-1:0]            d_ptr;
  logic                     d_wr;
  logic [AW-1:0]            d_wr_addr;
  logic                     d_rd_en;
  logic [AW-1:0]            d_rd_addr;
  logic [XW-1:0]            cnt_now;

  assign req.ready = (state == S_IDLE);
  assign pos_x     = XW'(req.position);
  assign cnt_x     = XW'(count);
  assign cnt_m1    = cnt_x - XW'(1);
  assign pos_p1    = pos_x + XW'(1);
  assign full      = (cnt_x >= XW'(CAPACITY));

  always_comb begin
    d_next    = S_DONE;
    d_cnt     = count;
    d_st      = ST_OK;
    d_rd      = '0;
    d_ptr     = '0;
    d_wr      = 1'b0;
    d_wr_addr = '0;
    d_rd_en   = 1'b0;
    d_rd_addr = '0;
    case (req.mode)
      MODE_APPEND: ins_x = cnt_x;
      MODE_FRONT:  ins_x = '0;
      default:     ins_x = pos_x;
    endcase
    case (req.mode)
      MODE_INSERT, MODE_APPEND, MODE_FRONT: begin
        if (req.mode == MODE_INSERT && pos_x > cnt_x) begin
          d_st = ST_BOUNDS;
        end else if (full) begin
          d_st = ST_FULL;
        end else begin
          d_cnt = count + CW'(1);
          if (ins_x == cnt_x) begin
            // slot at the tail: nothing to move
            d_wr      = 1'b1;
            d_wr_addr = ins_x[AW-1:0];
          end else begin
            d_rd_en   = 1'b1;
            d_rd_addr = cnt_m1[AW-1:0];
            d_ptr     = cnt_m1[AW-1:0];
            d_next    = S_UP;
          end
        end
      end
      MODE_REMOVE: begin
        if (pos_x >= cnt_x) begin
          d_st = ST_BOUNDS;
        end else begin
          d_cnt = count - CW'(1);
          if (pos_p1 != cnt_x) begin
            d_rd_en   = 1'b1;
            d_rd_addr = pos_p1[AW-1:0];
            d_ptr     = pos_p1[AW-1:0];
            d_next    = S_DN;
          end
        end
      end
      MODE_READ: begin
        if (pos_x >= cnt_x) begin
          d_st = ST_BOUNDS;
          d_rd = RD_MISS;
        end else begin
          d_rd_en   = 1'b1;
          d_rd_addr = pos_x[AW-1:0];
          d_next    = S_RD;
        end
      end
      MODE_WRITE: begin
        if (pos_x >= cnt_x) begin
          d_st = ST_BOUNDS;
        end else begin
          d_wr      = 1'b1;
          d_wr_addr = pos_x[AW-1:0];
        end
      end
      MODE_CLEAR: begin
        d_cnt = '0;
      end
      default: begin
      end
    endcase
  end

  // store port steering; reads and writes in a shift never hit the same entry
  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = '0;
    mem_wr_data = mem_rd_data;
    mem_rd_en   = 1'b0;
    mem_rd_addr = '0;
    case (state)
      S_IDLE: begin
        mem_wr_en   = req.valid && d_wr;
        mem_wr_addr = d_wr_addr;
        mem_wr_data = req.value;
        mem_rd_en   = req.valid && d_rd_en;
        mem_rd_addr = d_rd_addr;
      end
      S_UP: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = ptr + AW'(1);
        mem_rd_en   = (ptr != pos_reg);
        mem_rd_addr = ptr - AW'(1);
      end
      S_FILL: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = pos_reg;
        mem_wr_data = val_reg;
      end
      S_DN: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = ptr - AW'(1);
        mem_rd_en   = (CW'(ptr) != count);
        mem_rd_addr = ptr + AW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            state   <= d_next;
            count   <= d_cnt;
            res_st  <= d_st;
            res_rd  <= d_rd;
            ptr     <= d_ptr;
            pos_reg <= ins_x[AW-1:0];
            val_reg <= req.value;
          end
        end
        S_UP: begin
          if (ptr == pos_reg) begin
            state <= S_FILL;
          end else begin
            ptr <= ptr - AW'(1);
          end
        end
        S_FILL: begin
          state <= S_DONE;
        end
        S_DN: begin
          // count already holds the new value, which is the last index moved
          if (CW'(ptr) == count) begin
            state <= S_DONE;
          end else begin
            ptr <= ptr + AW'(1);
          end
        end
        S_RD: begin
          res_rd <= mem_rd_data;
          state  <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign cnt_now           = XW'(count);
  assign res_valid         = (state == S_DONE);
  assign res.read_value    = res_rd;
  assign res.status        = res_st;
  assign res.element_count = cnt_now[CNT_OUT_W-1:0];
  assign res.is_empty      = (count == '0);

endmodule

// ===== sim/tb_indexed_list_store_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_list_store_unit
// Drives request words into the list store and checks every result word
// against a shadow list kept in the bench: edge cases first, then a full store,
// random request mixes under several idle/stall settings, and a long output stall.
// ----------------------------------------------------------------------------
module tb_indexed_list_store_unit;
  import ils_pkg::*;

  localparam int LIST_CAP = CAPACITY_DEF;
  localparam int POS_TOP  = (1 << POS_W) - 1;
  // mode 7 is not a request; the block must answer it without touching the list
  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
  localparam logic [DATA_W-1:0] VAL_MAX     = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] VAL_MIN     = 32'h8000_0000;

  logic clk = 1'b0;
  logic rst;

  ils_req_if req_ch ();
  ils_rsp_if rsp_ch ();

  indexed_list_store_unit #(
    .CAPACITY(LIST_CAP)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always #6 clk = ~clk;

  // shadow of the list contents and its element count
  logic signed [DATA_W-1:0] shadow_list [LIST_CAP];
  int                       shadow_count;

  // result words owed by the block, oldest first
  rsp_t results_due [$];

  int errors;
  int send_idle_pct;   // chance per cycle that the sender holds back
  int rsp_stall_pct;   // chance per cycle that the sink drops ready
  int rsp_hold_left;   // forced sink hold-off, counted down by the sink process

  // Apply one request to the shadow list and return the word it must produce.
  function automatic rsp_t list_op_result(input logic [MODE_W-1:0] m,
                                          input logic [POS_W-1:0] p,
                                          input logic signed [DATA_W-1:0] v);
    rsp_t r;
    int   pos;
    int   ins_at;
    bit   full;
    bit   do_ins;
    pos          = int'(p);
    full         = shadow_count >= LIST_CAP;
    do_ins       = 1'b0;
    ins_at       = 0;
    r.read_value = '0;
    r.status     = ST_OK;
    case (m)
      MODE_INSERT: begin
        // bounds check wins over the full check
        if (pos > shadow_count) r.status = ST_BOUNDS;
        else if (full) r.status = ST_FULL;
        else begin
          do_ins = 1'b1;
          ins_at = pos;
        end
      end
      MODE_APPEND, MODE_FRONT: begin
        if (full) r.status = ST_FULL;
        else begin
          do_ins = 1'b1;
          ins_at = (m == MODE_APPEND) ? shadow_count : 0;
        end
      end
      MODE_REMOVE: begin
        if (pos >= shadow_count) r.status = ST_BOUNDS;
        else begin
          for (int i = pos; i < shadow_count - 1; i++) shadow_list[i] = shadow_list[i + 1];
          shadow_count--;
        end
      end
      MODE_READ: begin
        if (pos >= shadow_count) begin
          r.status     = ST_BOUNDS;
          r.read_value = RD_MISS;
        end else begin
          r.read_value = shadow_list[pos];
        end
      end
      MODE_WRITE: begin
        if (pos >= shadow_count) r.status = ST_BOUNDS;
        else shadow_list[pos] = v;
      end
      MODE_CLEAR: begin
        shadow_count = 0;
      end
      default: begin
      end
    endcase
    if (do_ins) begin
      for (int i = shadow_count; i > ins_at; i--) shadow_list[i] = shadow_list[i - 1];
      shadow_list[ins_at] = v;
      shadow_count++;
    end
    r.element_count = shadow_count[CNT_OUT_W-1:0];
    r.is_empty      = (shadow_count == 0);
    return r;
  endfunction

  // data values lean on the signed extremes now and then
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return '1;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  // Offer one request word; returns right after the edge that takes it.
  // valid is not dropped between back-to-back words.
  task automatic send_word(input logic [MODE_W-1:0] m, input logic [POS_W-1:0] p,
                           input logic [DATA_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid    <= 1'b0;
      req_ch.mode     <= MODE_W'($urandom);
      req_ch.position <= POS_W'($urandom);
      req_ch.value    <= $urandom;
      @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.mode     <= m;
    req_ch.position <= p;
    req_ch.value    <= v;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    results_due.push_back(list_op_result(m, p, v));
  endtask

  // Edge cases on a short list: empty-list misses, every mode, field extremes.
  task automatic test_edge_cases();
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    send_word(MODE_READ, 0, '0);            // miss on empty list reads back 1
    send_word(MODE_REMOVE, 0, '0);
    send_word(MODE_WRITE, 0, VAL_MAX);
    send_word(MODE_CLEAR, 0, '0);           // clear of empty list is fine
    send_word(MODE_UNUSED, POS_W'(POS_TOP), '1);
    send_word(MODE_INSERT, 1, VAL_MAX);     // past the end
    send_word(MODE_INSERT, POS_W'(POS_TOP), VAL_MAX);
    send_word(MODE_INSERT, 0, VAL_MAX);
    send_word(MODE_APPEND, POS_W'(POS_TOP), VAL_MIN);
    send_word(MODE_FRONT, POS_W'(POS_TOP), '1);
    send_word(MODE_INSERT, 3, '0);          // position == count is an append
    send_word(MODE_INSERT, 2, 32'h5a5a_5a5a);
    for (int i = 0; i <= 5; i++) send_word(MODE_READ, POS_W'(i), '0);
    send_word(MODE_WRITE, 4, 32'ha5a5_a5a5);
    send_word(MODE_READ, 4, '0);
    send_word(MODE_REMOVE, 0, '0);
    send_word(MODE_REMOVE, POS_W'(shadow_count - 1), '0);
    send_word(MODE_REMOVE, 1, '0);
    send_word(MODE_REMOVE, POS_W'(POS_TOP), '0);
    send_word(MODE_UNUSED, 0, VAL_MIN);
    send_word(MODE_CLEAR, POS_W'(POS_TOP), '1);
    send_word(MODE_READ, 0, '0);
  endtask

  // Fill the store, then poke at it while full and shift it end to end.
  task automatic test_full_store();
    send_idle_pct = 20;
    rsp_stall_pct = 20;
    while (shadow_count < LIST_CAP) send_word(MODE_APPEND, POS_W'($urandom), pick_value());
    send_word(MODE_INSERT, 0, VAL_MAX);                   // full
    send_word(MODE_INSERT, 300, VAL_MAX);                 // bounds beats full
    send_word(MODE_INSERT, POS_W'(LIST_CAP), VAL_MIN);    // position == count, full
    send_word(MODE_APPEND, 0, VAL_MIN);
    send_word(MODE_FRONT, 0, VAL_MIN);
    send_word(MODE_READ, POS_W'(LIST_CAP - 1), '0);
    send_word(MODE_WRITE, POS_W'(LIST_CAP - 1), VAL_MIN);
    send_word(MODE_READ, POS_W'(LIST_CAP - 1), '0);
    send_word(MODE_REMOVE, 0, '0);                        // longest shift down
    send_word(MODE_FRONT, 0, VAL_MAX);                    // longest shift up
    send_word(MODE_READ, 0, '0);
    send_word(MODE_REMOVE, POS_W'(LIST_CAP - 1), '0);
    send_word(MODE_INSERT, POS_W'(LIST_CAP / 2), '1);
    send_word(MODE_READ, POS_W'(LIST_CAP / 2), '0);
    send_word(MODE_CLEAR, 0, '0);
  endtask

  // Random request mix. Most positions land inside the list so the shifts
  // actually happen; the rest are anywhere in the 9-bit range.
  task automatic test_random_mix(input int n_words, input int idle_pct, input int stall_pct);
    int                  kind;
    logic [MODE_W-1:0]   m;
    logic [POS_W-1:0]    p;
    logic [DATA_W-1:0]   v;
    send_idle_pct = idle_pct;
    rsp_stall_pct = stall_pct;
    repeat (n_words) begin
      kind = $urandom_range(99);
      v    = pick_value();
      p    = POS_W'($urandom_range(POS_TOP, 0));
      if (kind < 25) begin
        m = MODE_INSERT;
        if ($urandom_range(9) != 0) p = POS_W'($urandom_range(shadow_count, 0));
      end else if (kind < 40) begin
        m = MODE_APPEND;
      end else if (kind < 50) begin
        m = MODE_FRONT;
      end else if (kind < 96) begin
        m = (kind < 65) ? MODE_REMOVE : (kind < 80) ? MODE_READ : MODE_WRITE;
        if (shadow_count > 0 && $urandom_range(9) != 0) begin
          p = POS_W'($urandom_range(shadow_count - 1, 0));
        end
      end else if (kind < 98) begin
        m = MODE_CLEAR;
      end else begin
        m = MODE_UNUSED;
      end
      send_word(m, p, v);
    end
  endtask

  // Sink holds ready low for a long stretch while words keep coming, so the
  // block backs up and has to hold off its input.
  task automatic test_output_stall();
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    rsp_hold_left = 600;
    for (int i = 0; i < 20; i++) begin
      if (i % 2 == 0) send_word(MODE_APPEND, 0, pick_value());
      else send_word(MODE_READ, POS_W'($urandom_range(shadow_count - 1, 0)), '0);
    end
  endtask

  // Result sink: checks each accepted word, then picks ready for the next cycle.
  initial begin : result_sink
    rsp_t seen;
    rsp_t due;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) begin
        seen.read_value    = rsp_ch.read_value;
        seen.status        = rsp_ch.status;
        seen.element_count = rsp_ch.element_count;
        seen.is_empty      = rsp_ch.is_empty;
        if (results_due.size() == 0) begin
          $display("%0t: result word with none due: rd=%0d st=%0d cnt=%0d empty=%0b",
                   $time, seen.read_value, seen.status, seen.element_count, seen.is_empty);
          errors++;
        end else begin
          due = results_due.pop_front();
          if (seen.read_value !== due.read_value) begin
            $display("%0t: read_value expected %0d actual %0d",
                     $time, due.read_value, seen.read_value);
            errors++;
          end
          if (seen.status !== due.status) begin
            $display("%0t: status expected %0d actual %0d", $time, due.status, seen.status);
            errors++;
          end
          if (seen.element_count !== due.element_count) begin
            $display("%0t: element_count expected %0d actual %0d",
                     $time, due.element_count, seen.element_count);
            errors++;
          end
          if (seen.is_empty !== due.is_empty) begin
            $display("%0t: is_empty expected %0b actual %0b", $time, due.is_empty, seen.is_empty);
            errors++;
          end
        end
      end
      if (rsp_hold_left > 0) begin
        rsp_hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #40_000_000;
    $display("[indexed_list_store_unit] ERROR");
    $finish;
  end

  initial begin : run_tests
    int drain_cycles;
    errors          = 0;
    shadow_count    = 0;
    send_idle_pct   = 0;
    rsp_stall_pct   = 0;
    rsp_hold_left   = 0;
    rst             <= 1'b1;
    req_ch.valid    <= 1'b0;
    req_ch.mode     <= '0;
    req_ch.position <= '0;
    req_ch.value    <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_edge_cases();
    test_full_store();
    test_random_mix(375, 0, 0);
    test_random_mix(375, 73, 0);
    test_random_mix(375, 0, 73);
    test_random_mix(375, 20, 20);
    test_output_stall();

    // drain: the longest request is a full-length shift of the store
    req_ch.valid  <= 1'b0;
    rsp_stall_pct = 0;
    drain_cycles  = 0;
    while (results_due.size() != 0 && drain_cycles < 20000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (LIST_CAP + 40) @(posedge clk);
    if (results_due.size() != 0) begin
      $display("%0t: %0d result words never arrived", $time, results_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("[indexed_list_store_unit] OK");
    end else begin
      $display("[indexed_list_store_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ils_pkg.sv
rtl/ils_if.sv
rtl/ils_mem.sv
rtl/ils_ctrl.sv
rtl/indexed_list_store_unit.sv
sim/tb_indexed_list_store_unit.sv
